>>> rtl/rtfp_pkg.sv
// Shared types and constants for the radar target frame parser.
// No dependencies; imported by every module of the block.
package rtfp_pkg;

    // Frame header bytes
    localparam logic [7:0] HDR_FIRST  = 8'hFD;
    localparam logic [7:0] HDR_SECOND = 8'hFC;

    // Threshold register
    localparam int         THRESH_W     = 15;
    localparam logic [14:0] THRESH_RESET = 15'd10;

    // Capture windows: three targets of six bytes each, at frame bytes
    // 8, 16 and 24.
    localparam int TGT_SLOTS    = 3;
    localparam int WIN_LEN      = 6;
    localparam int WIN_BASE     = 8;
    localparam int WIN_STRIDE   = 8;
    localparam int CAP_BYTES    = TGT_SLOTS * WIN_LEN;
    localparam int CAP_IDX_W    = $clog2(CAP_BYTES);

    // One target as captured from the frame
    typedef struct packed {
        logic [15:0] speed;
        logic [15:0] y;
        logic [15:0] x;
    } target_t;

    typedef target_t [TGT_SLOTS-1:0] target_arr_t;

    // Frame completion status handed from the parser core to the result stage
    typedef struct packed {
        logic        done;
        target_arr_t targets;
    } frame_status_t;

endpackage

>>> rtl/rtfp_in_stage.sv
// Input register of the radar target frame parser: holds one received byte.
// Depends on rtfp_pkg.
module rtfp_in_stage
    import rtfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       downstream_free,
    output logic       step,
    output logic [7:0] byte_out
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       accept;

    // The held item moves on whenever the result stage can take a result.
    assign step     = in_valid_reg && downstream_free;
    assign s_ready  = !in_valid_reg || downstream_free;
    assign accept   = s_valid && s_ready;
    assign byte_out = in_byte_reg;

    // Occupancy of the input register.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_rx_byte;
        end
    end

endmodule

>>> rtl/rtfp_frame_core.sv
// Frame parser core: header hunt, frame byte counter and target byte capture.
// Depends on rtfp_pkg for header codes, capture window layout and types.
module rtfp_frame_core
    import rtfp_pkg::*;
#(
    parameter int FRAME_LEN = 47
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    output frame_status_t status
);

    localparam int PosW = $clog2(FRAME_LEN);

    logic [PosW-1:0]      pos_reg;
    logic [PosW-1:0]      pos_next;
    logic                 inside_reg;
    logic                 inside_next;
    logic [7:0]           cap_reg  [CAP_BYTES];
    logic [7:0]           cap_next [CAP_BYTES];
    logic                 cap_we;
    logic [CAP_IDX_W-1:0] cap_idx;
    logic [PosW:0]        pos_ext;
    logic [PosW:0]        pos_inc;
    logic                 done;

    assign pos_ext = {1'b0, pos_reg};
    assign pos_inc = pos_ext + (PosW+1)'(1);

    // Work out which capture byte, if any, the current frame position lands on.
    always_comb begin
        cap_we  = 1'b0;
        cap_idx = '0;
        for (int w = 0; w < TGT_SLOTS; w++) begin
            if (pos_ext >= (PosW+1)'(WIN_BASE + w * WIN_STRIDE) &&
                pos_ext <  (PosW+1)'(WIN_BASE + w * WIN_STRIDE + WIN_LEN)) begin
                cap_we  = 1'b1;
                cap_idx = CAP_IDX_W'(pos_ext - (PosW+1)'(WIN_BASE + w * WIN_STRIDE))
                          + CAP_IDX_W'(w * WIN_LEN);
            end
        end
    end

    // Header hunt and frame counting.
    always_comb begin
        pos_next    = pos_reg;
        inside_next = inside_reg;
        done        = 1'b0;
        if (step) begin
            if (!inside_reg) begin
                priority if (pos_reg == PosW'(0) && rx_byte == HDR_FIRST) begin
                    pos_next = PosW'(1);
                end else if (pos_reg == PosW'(1) && rx_byte == HDR_SECOND) begin
                    pos_next    = PosW'(2);
                    inside_next = 1'b1;
                end else begin
                    pos_next = '0;
                end
            end else if (pos_inc < (PosW+1)'(FRAME_LEN)) begin
                pos_next = pos_inc[PosW-1:0];
            end else begin
                pos_next    = '0;
                inside_next = 1'b0;
                done        = 1'b1;
            end
        end
    end

    // Capture bytes; the byte that completes a frame is already visible.
    generate
        for (genvar i = 0; i < CAP_BYTES; i++) begin : g_cap
            assign cap_next[i] = (step && inside_reg && cap_we &&
                                  cap_idx == CAP_IDX_W'(i)) ? rx_byte : cap_reg[i];

            always_ff @(posedge aclk) begin
                cap_reg[i] <= cap_next[i];
            end
        end
    endgenerate

    // Assemble little-endian target fields.
    generate
        for (genvar t = 0; t < TGT_SLOTS; t++) begin : g_tgt
            assign status.targets[t].x     = {cap_next[t*WIN_LEN+1], cap_next[t*WIN_LEN]};
            assign status.targets[t].y     = {cap_next[t*WIN_LEN+3], cap_next[t*WIN_LEN+2]};
            assign status.targets[t].speed = {cap_next[t*WIN_LEN+5], cap_next[t*WIN_LEN+4]};
        end
    endgenerate

    assign status.done = done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            inside_reg <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            inside_reg <= inside_next;
        end
    end

endmodule

>>> rtl/rtfp_result_stage.sv
// Result stage: target presence count and the output register of the parser.
// Depends on rtfp_pkg for target types and the threshold width.
module rtfp_result_stage
    import rtfp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  frame_status_t       status,
    input  logic [THRESH_W-1:0] threshold,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output target_arr_t         targets,
    output logic [1:0]          target_count
);

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   load;
    logic [TGT_SLOTS-1:0]   present;
    logic [1:0]             count;
    target_arr_t            targets_reg;
    logic [1:0]             count_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = step && status.done;

    // A target is present when |x| or |y| exceeds the threshold; the
    // magnitude is 17 bits wide so that -32768 gives 32768.
    always_comb begin
        logic [16:0] ax;
        logic [16:0] ay;
        for (int t = 0; t < TGT_SLOTS; t++) begin
            ax = status.targets[t].x[15] ? (17'h10000 - {1'b0, status.targets[t].x})
                                         : {1'b0, status.targets[t].x};
            ay = status.targets[t].y[15] ? (17'h10000 - {1'b0, status.targets[t].y})
                                         : {1'b0, status.targets[t].y};
            present[t] = (ax > {2'b00, threshold}) || (ay > {2'b00, threshold});
        end
    end

    // Count is one plus the highest present target.
    always_comb begin
        priority if (present[2]) begin
            count = 2'd3;
        end else if (present[1]) begin
            count = 2'd2;
        end else if (present[0]) begin
            count = 2'd1;
        end else begin
            count = 2'd0;
        end
    end

    // Output valid tracking.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            targets_reg <= status.targets;
            count_reg   <= count;
        end
    end

    assign m_valid      = m_valid_reg;
    assign targets      = targets_reg;
    assign target_count = count_reg;

endmodule

>>> rtl/radar_target_frame_parser.sv
// Radar target frame parser, top level.
// Depends on rtfp_pkg, rtfp_in_stage, rtfp_frame_core and rtfp_result_stage.
//
// Usage: the input channel (s_valid, s_ready, s_rx_byte) takes one received
// byte per item. The parser hunts for the header 0xFD 0xFC, counts FRAME_LEN
// frame bytes and captures three targets (x, y, speed, little-endian signed).
// On the byte that completes a frame it emits one result item on the output
// channel (m_valid, m_ready, m_target*_*, m_target_count); other bytes give
// no result. The user writes the threshold through cfg_valid_threshold_we and
// cfg_valid_threshold only while the block is idle; the block does not enforce it.
// Throughput: one byte per cycle while the output register is free, set by
// the combinational parse between the input register and the result register.
// m_valid is set as the last byte of a frame leaves the input register.
// Reset (aresetn low, synchronous) clears the frame position, drops any held
// byte and result, and loads the threshold with 10.
// When the receiver stalls, a finished result waits in the output register;
// the input register holds at most one further byte, and while it is full
// s_ready stays low until the result is taken.
module radar_target_frame_parser
    import rtfp_pkg::*;
#(
    parameter int FRAME_LEN = 47
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_target0_x,
    output logic signed [15:0]  m_target0_y,
    output logic signed [15:0]  m_target0_speed,
    output logic signed [15:0]  m_target1_x,
    output logic signed [15:0]  m_target1_y,
    output logic signed [15:0]  m_target1_speed,
    output logic signed [15:0]  m_target2_x,
    output logic signed [15:0]  m_target2_y,
    output logic signed [15:0]  m_target2_speed,
    output logic [1:0]          m_target_count,
    input  logic                cfg_valid_threshold_we,
    input  logic [THRESH_W-1:0] cfg_valid_threshold
);

    logic [THRESH_W-1:0] thresh_reg;
    logic                step;
    logic [7:0]          held_byte;
    logic                out_free;
    frame_status_t       status;
    target_arr_t         targets;

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_valid_threshold_we) begin
            thresh_reg <= cfg_valid_threshold;
        end
    end

    rtfp_in_stage u_in_stage (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .downstream_free (out_free),
        .step            (step),
        .byte_out        (held_byte)
    );

    rtfp_frame_core #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (held_byte),
        .status  (status)
    );

    rtfp_result_stage u_result_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .status       (status),
        .threshold    (thresh_reg),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .targets      (targets),
        .target_count (m_target_count)
    );

    // Fan the result out onto the field ports.
    assign m_target0_x     = targets[0].x;
    assign m_target0_y     = targets[0].y;
    assign m_target0_speed = targets[0].speed;
    assign m_target1_x     = targets[1].x;
    assign m_target1_y     = targets[1].y;
    assign m_target1_speed = targets[1].speed;
    assign m_target2_x     = targets[2].x;
    assign m_target2_y     = targets[2].y;
    assign m_target2_speed = targets[2].speed;

endmodule

>>> sim/radar_target_frame_parser_test.sv
// Self-checking testbench for radar_target_frame_parser.
// Depends on rtfp_pkg and the parser RTL. It drives byte items, predicts each
// frame result and checks the result channel field by field.
module radar_target_frame_parser_test;
    import rtfp_pkg::*;

    localparam int FRAME_LEN     = 47;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_OFF      = 300;

    // Nine 16-bit values in port order: x, y, speed of targets 0, 1 and 2.
    typedef logic [0:8][15:0] target_vals_t;

    typedef struct packed {
        target_vals_t vals;
        logic [1:0]   count;
    } frame_result_t;

    // One directed frame: threshold to run it with, bytes sent before the
    // header, the target values, and a typed-in count where one is given.
    typedef struct packed {
        logic [THRESH_W-1:0] thresh;
        logic [2:0]          npre;
        logic [0:3][7:0]     pre;
        target_vals_t        vals;
        logic                typed;
        logic [1:0]          count;
    } frame_row_t;

    localparam frame_row_t DIR_ROWS [0:10] = '{
        // Noise before the header is ignored; all targets at zero.
        '{15'd10, 3'd2, {8'h00, 8'hFF, 8'h00, 8'h00},
          {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
           16'h0000, 16'h0000, 16'h0000}, 1'b1, 2'd0},
        // A broken header, then a frame with only the first target present.
        '{15'd10, 3'd2, {8'hFD, 8'h00, 8'h00, 8'h00},
          {16'h000B, 16'h0000, 16'h0005, 16'h0000, 16'h0000, 16'h0000,
           16'h0000, 16'h0000, 16'h0000}, 1'b1, 2'd1},
        // The second 0xFD of a pair is not taken as a new header start.
        '{15'd10, 3'd3, {8'hFD, 8'hFD, 8'hFC, 8'h00},
          {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
           16'hFFF5, 16'h0000, 16'h0000}, 1'b1, 2'd3},
        // Values equal to the threshold do not count, nor does speed.
        '{15'd10, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00},
          {16'hFFF6, 16'h0000, 16'h8000, 16'h0000, 16'h000A, 16'h7FFF,
           16'h0000, 16'h0000, 16'h0000}, 1'b1, 2'd0},
        // Every field at its extremes.
        '{15'd10, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00},
          {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
           16'h8000, 16'h8000, 16'h8000}, 1'b1, 2'd3},
        // Full-scale negative x exceeds even the largest threshold.
        '{15'd32767, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00},
          {16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8001, 16'h0000,
           16'h0000, 16'h0000, 16'h0000}, 1'b1, 2'd1},
        '{15'd32767, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00},
          {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000,
           16'h0000, 16'h0000, 16'h8000}, 1'b1, 2'd2},
        // Zero threshold: any non-zero coordinate is present.
        '{15'd0, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00},
          {16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
           16'h0000, 16'h0000, 16'h0000}, 1'b1, 2'd2},
        '{15'd0, 3'd0, {8'h00, 8'h00, 8'h00, 8'h00},
          {16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
           16'h0000, 16'h0000, 16'h0000}, 1'b1, 2'd1},
        // Mixed patterns, checked against the predictor.
        '{15'd0, 3'd1, {8'hFC, 8'h00, 8'h00, 8'h00},
          {16'h1234, 16'hABCD, 16'h00FF, 16'hFF00, 16'h5A5A, 16'hA5A5,
           16'h0FF0, 16'hF00F, 16'h0000}, 1'b0, 2'd0},
        // A stray 0xFD makes the real header be missed; the frame body is
        // parsed from wherever the filler forms a header.
        '{15'd10, 3'd1, {8'hFD, 8'h00, 8'h00, 8'h00},
          {16'h0101, 16'hFEFE, 16'h7F80, 16'h807F, 16'h0013, 16'hFFEC,
           16'h000B, 16'hFFF5, 16'hC3C3}, 1'b0, 2'd0}
    };

    string field_names [0:8] = '{"target0_x", "target0_y", "target0_speed",
                                 "target1_x", "target1_y", "target1_speed",
                                 "target2_x", "target2_y", "target2_speed"};

    logic                  aclk                   = 1'b0;
    logic                  aresetn                = 1'b0;
    logic                  s_valid                = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte              = 8'h00;
    logic                  m_valid;
    logic                  m_ready                = 1'b0;
    logic signed [15:0]    m_target0_x, m_target0_y, m_target0_speed;
    logic signed [15:0]    m_target1_x, m_target1_y, m_target1_speed;
    logic signed [15:0]    m_target2_x, m_target2_y, m_target2_speed;
    logic [1:0]            m_target_count;
    logic                  cfg_valid_threshold_we = 1'b0;
    logic [THRESH_W-1:0]   cfg_valid_threshold    = '0;

    // Parser state as the testbench sees it.
    logic [5:0]            frame_pos   = 6'd0;
    logic                  tb_inside   = 1'b0;
    logic [7:0]            captured [CAP_BYTES];
    logic [THRESH_W-1:0]   thresh_copy = THRESH_RESET;

    frame_result_t         pending_frames [$];
    frame_result_t         typed_result;
    bit                    typed_armed   = 1'b0;
    int                    frames_parsed = 0;
    int                    mismatches    = 0;
    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    int                    rx_hold       = 0;
    int                    cycle_count   = 0;

    radar_target_frame_parser #(
        .FRAME_LEN(FRAME_LEN)
    ) dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_rx_byte              (s_rx_byte),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_target0_x            (m_target0_x),
        .m_target0_y            (m_target0_y),
        .m_target0_speed        (m_target0_speed),
        .m_target1_x            (m_target1_x),
        .m_target1_y            (m_target1_y),
        .m_target1_speed        (m_target1_speed),
        .m_target2_x            (m_target2_x),
        .m_target2_y            (m_target2_y),
        .m_target2_speed        (m_target2_speed),
        .m_target_count         (m_target_count),
        .cfg_valid_threshold_we (cfg_valid_threshold_we),
        .cfg_valid_threshold    (cfg_valid_threshold)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // True when the magnitude of a coordinate is above the threshold.
    function automatic bit exceeds(input logic [15:0] v);
        logic [16:0] mag;
        mag = v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
        return mag > {2'b00, thresh_copy};
    endfunction

    // Advances the parser state by one byte; done is set on frame completion.
    task automatic parse_byte(input logic [7:0] b, output bit done,
                              output frame_result_t res);
        int pos;
        int t;
        done = 1'b0;
        res  = '0;
        pos  = frame_pos;
        if (!tb_inside) begin
            if (pos == 0 && b == HDR_FIRST) begin
                frame_pos = 6'd1;
            end else if (pos == 1 && b == HDR_SECOND) begin
                frame_pos = 6'd2;
                tb_inside = 1'b1;
            end else begin
                frame_pos = 6'd0;
            end
            return;
        end
        for (t = 0; t < TGT_SLOTS; t++) begin
            if (pos >= WIN_BASE + t * WIN_STRIDE &&
                    pos < WIN_BASE + t * WIN_STRIDE + WIN_LEN) begin
                captured[t * WIN_LEN + pos - WIN_BASE - t * WIN_STRIDE] = b;
            end
        end
        if (pos + 1 < FRAME_LEN) begin
            frame_pos = 6'(pos + 1);
            return;
        end
        tb_inside = 1'b0;
        frame_pos = 6'd0;
        done      = 1'b1;
        for (t = 0; t < 9; t++) begin
            res.vals[t] = {captured[2 * t + 1], captured[2 * t]};
        end
        // The highest present target sets the count.
        for (t = 0; t < TGT_SLOTS; t++) begin
            if (exceeds(res.vals[3 * t]) || exceeds(res.vals[3 * t + 1])) begin
                res.count = 2'(t + 1);
            end
        end
    endtask

    // Offers one byte, waits for its acceptance and records any expected frame.
    task automatic send_byte(input logic [7:0] b);
        bit            done;
        frame_result_t res;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, done, res);
        if (done) begin
            frames_parsed++;
            if (typed_armed) begin
                pending_frames.push_back(typed_result);
                typed_armed = 1'b0;
            end else begin
                pending_frames.push_back(res);
            end
        end
    endtask

    // Sends a whole frame: header, then the body with the targets in place.
    task automatic send_frame(input target_vals_t vals, input bit random_fill);
        int         pos;
        int         t;
        int         off;
        logic [7:0] b;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        for (pos = 2; pos < FRAME_LEN; pos++) begin
            t   = (pos - WIN_BASE) / WIN_STRIDE;
            off = (pos - WIN_BASE) % WIN_STRIDE;
            if (pos >= WIN_BASE && t < TGT_SLOTS && off < WIN_LEN) begin
                b = vals[t * 3 + off / 2][8 * (off % 2) +: 8];
            end else if (random_fill) begin
                b = 8'($urandom_range(255));
            end else begin
                // Header bytes inside a frame are plain data.
                b = (pos % 2) ? HDR_SECOND : HDR_FIRST;
            end
            send_byte(b);
        end
    endtask

    // Stops offering items until every expected frame has come out.
    task automatic wait_for_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] v);
        @(negedge aclk);
        cfg_valid_threshold_we <= 1'b1;
        cfg_valid_threshold    <= v;
        @(negedge aclk);
        cfg_valid_threshold_we <= 1'b0;
        thresh_copy = v;
    endtask

    // Coordinates biased towards the threshold edge and the extremes.
    function automatic logic [15:0] rand_coord();
        int m;
        m = 0;
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4: m = int'(thresh_copy) + int'($urandom_range(2)) - 1;
            5: m = int'($urandom_range(thresh_copy));
            default: return 16'($urandom);
        endcase
        if (m < 0) m = 0;
        return $urandom_range(1) ? 16'(-m) : 16'(m);
    endfunction

    // Receiver: random stalls, or a long hold-off while rx_hold runs down.
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result item with the oldest expected frame.
    always @(posedge aclk) begin : check_results
        frame_result_t seen;
        frame_result_t want;
        int            k;
        if (aresetn && m_valid && m_ready) begin
            seen.vals  = {m_target0_x, m_target0_y, m_target0_speed,
                          m_target1_x, m_target1_y, m_target1_speed,
                          m_target2_x, m_target2_y, m_target2_speed};
            seen.count = m_target_count;
            if (pending_frames.size() == 0) begin
                $display("%0t: result item with none expected, target_count %0d",
                         $time, seen.count);
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                for (k = 0; k < 9; k++) begin
                    if (seen.vals[k] !== want.vals[k]) begin
                        $display("%0t: %s expected %0d, got %0d", $time, field_names[k],
                                 $signed(want.vals[k]), $signed(seen.vals[k]));
                        mismatches++;
                    end
                end
                if (seen.count !== want.count) begin
                    $display("%0t: target_count expected %0d, got %0d",
                             $time, want.count, seen.count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        frame_row_t          row;
        target_vals_t        vals;
        logic [THRESH_W-1:0] new_thr;
        logic [7:0]          b;
        int                  i;
        int                  j;
        int                  seg;
        int                  results_before;

        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed frames.
        send_idle_pct = 10;
        stall_pct     = 74;
        for (i = 0; i < $size(DIR_ROWS); i++) begin
            row = DIR_ROWS[i];
            if (row.thresh != thresh_copy) begin
                wait_for_idle();
                write_threshold(row.thresh);
            end
            for (j = 0; j < row.npre; j++) begin
                send_byte(row.pre[j]);
            end
            if (row.typed) begin
                typed_result.vals  = row.vals;
                typed_result.count = row.count;
                typed_armed        = 1'b1;
            end
            send_frame(row.vals, 1'b0);
        end

        // Random segments: receiver idling, then sender idling, then neither.
        for (seg = 0; seg < 6; seg++) begin
            send_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 74 : 0;
            stall_pct     = (seg < 2) ? 74 : (seg < 4) ? 10 : 0;
            wait_for_idle();
            case (seg)
                0:       new_thr = THRESH_W'($urandom_range(200));
                1:       new_thr = '0;
                2:       new_thr = '1;
                3:       new_thr = THRESH_W'($urandom);
                4:       new_thr = THRESH_W'($urandom_range(2000));
                default: new_thr = THRESH_W'($urandom_range(100));
            endcase
            write_threshold(new_thr);
            // Hold the receiver off so the block fills and stalls its input.
            if (seg == 4) rx_hold = HOLD_OFF;
            results_before = frames_parsed;
            while (frames_parsed - results_before < 3) begin
                case ($urandom_range(9))
                    0: begin
                        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
                    end
                    1: begin
                        b = 8'($urandom_range(255));
                        if (b == HDR_SECOND) b = ~HDR_SECOND;
                        send_byte(HDR_FIRST);
                        send_byte(b);
                    end
                    2: begin
                        send_byte(HDR_FIRST);
                        send_byte(HDR_FIRST);
                        send_byte(HDR_SECOND);
                    end
                    default: begin
                        for (j = 0; j < 9; j++) vals[j] = rand_coord();
                        send_frame(vals, 1'b1);
                    end
                endcase
            end
        end

        wait_for_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
